### src/pad_to_keyboard_report_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pad to keyboard report block
// Shared immediate-implication and next-cycle forms of a concurrent check.
// ----------------------------------------------------------------------------
`ifndef PAD_TO_KEYBOARD_REPORT_TOP_MACROS_SVH
`define PAD_TO_KEYBOARD_REPORT_TOP_MACROS_SVH

// Check cons in the same cycle as ante, outside reset
`define P2K_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante, outside reset
`define P2K_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check cons in the same cycle as ante, reset included
`define P2K_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/p2k_pkg.sv
// ----------------------------------------------------------------------------
// p2k_pkg
// Constants, keycode tables and shared types of the pad to keyboard report block.
// ----------------------------------------------------------------------------
package p2k_pkg;

	localparam int BUTTON_COUNT = 16;
	localparam int SLOT_COUNT   = 6;
	localparam int MAX_SLOTS    = 6;
	localparam int BTN_W        = 16;
	localparam int KEY_W        = 8;
	localparam int IDX_W        = 4;
	localparam int QUEUE_DEPTH  = 2;

	localparam int POS_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int SLOT_IW  = $clog2(MAX_SLOTS);
	localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	// Keycodes per button position
	localparam logic [KEY_W-1:0] CODE_ONE [BTN_W] = '{
		8'd44, 8'd8, 8'd21, 8'd0, 8'd9, 8'd6, 8'd27, 8'd20,
		8'd0, 8'd40, 8'd0, 8'd0, 8'd26, 8'd22, 8'd4, 8'd7
	};
	localparam logic [KEY_W-1:0] CODE_TWO [BTN_W] = '{
		8'd89, 8'd90, 8'd91, 8'd0, 8'd92, 8'd93, 8'd94, 8'd98,
		8'd0, 8'd88, 8'd0, 8'd0, 8'd82, 8'd81, 8'd80, 8'd79
	};

	// Positions whose changes are kept: inside the button range and mapped on pad one
	function automatic logic [BTN_W-1:0] map_mask();
		logic [BTN_W-1:0] m;
		m = '0;
		for (int i = 0; i < BTN_W; i++) begin
			m[i] = (i < BUTTON_COUNT) && (CODE_ONE[i] != '0);
		end
		return m;
	endfunction

	// One poll as handed from the front end to the back end
	typedef struct packed {
		logic [BTN_W-1:0] chg_one;
		logic [BTN_W-1:0] chg_two;
		logic [BTN_W-1:0] lvl_one;
		logic [BTN_W-1:0] lvl_two;
	} p2k_work_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} p2k_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_EMIT
	} p2k_bk_state_t;

endpackage

### src/p2k_if.sv
// ----------------------------------------------------------------------------
// p2k channel interfaces
// Valid/ready channels for pad polls in and keyboard reports out.
// ----------------------------------------------------------------------------
interface p2k_poll_if;
	logic        valid;
	logic        ready;
	logic [15:0] pad_one_buttons;
	logic [15:0] pad_two_buttons;

	modport source (output valid, output pad_one_buttons, output pad_two_buttons,
		input ready);
	modport sink (input valid, input pad_one_buttons, input pad_two_buttons,
		output ready);
endinterface

interface p2k_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] slot_one;
	logic [7:0] slot_two;
	logic [7:0] slot_three;
	logic [7:0] slot_four;
	logic [7:0] slot_five;
	logic [7:0] slot_six;
	logic       indicator;

	modport source (output valid, output slot_one, output slot_two, output slot_three,
		output slot_four, output slot_five, output slot_six, output indicator,
		input ready);
	modport sink (input valid, input slot_one, input slot_two, input slot_three,
		input slot_four, input slot_five, input slot_six, input indicator,
		output ready);
endinterface

### src/p2k_front.sv
// ----------------------------------------------------------------------------
// p2k_front
// Accepts polls, finds changed mapped buttons and queues the work for the back end.
// ----------------------------------------------------------------------------
module p2k_front import p2k_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	p2k_poll_if.sink          poll,
	input  p2k_qstat_t        qstat,
	output logic              push,
	output p2k_work_t         push_data
);

	localparam logic [BTN_W-1:0] MASK = map_mask();

	logic [BTN_W-1:0] prev_one_q;
	logic [BTN_W-1:0] prev_two_q;

	// Take a beat whenever the queue has room
	assign poll.ready = !qstat.full;
	assign push       = poll.valid && poll.ready;

	// Classify: changed bits at mapped positions, plus the new levels
	always_comb begin
		push_data.chg_one = (poll.pad_one_buttons ^ prev_one_q) & MASK;
		push_data.chg_two = (poll.pad_two_buttons ^ prev_two_q) & MASK;
		push_data.lvl_one = poll.pad_one_buttons;
		push_data.lvl_two = poll.pad_two_buttons;
	end

	// Hold the previous words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_one_q <= '0;
			prev_two_q <= '0;
		end else if (push) begin
			prev_one_q <= poll.pad_one_buttons;
			prev_two_q <= poll.pad_two_buttons;
		end
	end

endmodule

### src/p2k_queue.sv
// ----------------------------------------------------------------------------
// p2k_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module p2k_queue import p2k_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  p2k_work_t  push_data,
	input  logic       pop,
	output p2k_work_t  pop_data,
	output p2k_qstat_t qstat
);

	p2k_work_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/p2k_back.sv
// ----------------------------------------------------------------------------
// p2k_back
// Walks each queued poll one position and pad per cycle, updates the key slots
// and the indicator, and registers the finished report.
// ----------------------------------------------------------------------------
module p2k_back import p2k_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  p2k_qstat_t  qstat,
	input  p2k_work_t   pop_data,
	output logic        pop,
	p2k_report_if.source report
);

	p2k_bk_state_t      state_q, state_d;
	p2k_work_t          work_q;
	logic [POS_W-1:0]   pos_q;
	logic               pad_q;
	logic [KEY_W-1:0]   slots_q [MAX_SLOTS];
	logic               ind_q;
	logic               rpt_valid_q;
	logic [KEY_W-1:0]   rpt_slot_q [MAX_SLOTS];
	logic               rpt_ind_q;

	logic               load;
	logic               step;
	logic               emit;
	logic               last_step;
	logic [IDX_W-1:0]   idx;
	logic               chg;
	logic               lvl;
	logic [KEY_W-1:0]   code;
	logic               hit;
	logic [SLOT_IW-1:0] hit_idx;

	// Select the current position and pad
	always_comb begin
		idx       = IDX_W'(pos_q);
		chg       = pad_q ? work_q.chg_two[idx] : work_q.chg_one[idx];
		lvl       = pad_q ? work_q.lvl_two[idx] : work_q.lvl_one[idx];
		code      = pad_q ? CODE_TWO[idx] : CODE_ONE[idx];
		last_step = pad_q && (pos_q == POS_W'(BUTTON_COUNT - 1));
	end

	// Find the first empty slot for a press, the first matching slot for a release
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (!hit && (lvl ? (slots_q[s] == '0) : (slots_q[s] == code))) begin
				hit     = 1'b1;
				hit_idx = SLOT_IW'(s);
			end
		end
	end

	// Next state and controls
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					load    = 1'b1;
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				step = 1'b1;
				if (last_step) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!rpt_valid_q || report.ready) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the work of one poll
	always_ff @(posedge clk) begin
		if (load) begin
			work_q <= pop_data;
		end
	end

	// Advance the walk: pad one, then pad two, then next position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pad_q <= 1'b0;
		end else if (load) begin
			pos_q <= '0;
			pad_q <= 1'b0;
		end else if (step) begin
			pad_q <= !pad_q;
			if (pad_q) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Apply one change to the slots and the indicator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				slots_q[s] <= '0;
			end
			ind_q <= 1'b1;
		end else if (step && chg && hit) begin
			slots_q[hit_idx] <= lvl ? code : '0;
			ind_q            <= !lvl;
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (emit) begin
			rpt_valid_q <= 1'b1;
		end else if (report.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				rpt_slot_q[s] <= slots_q[s];
			end
			rpt_ind_q <= ind_q;
		end
	end

	assign report.valid      = rpt_valid_q;
	assign report.slot_one   = rpt_slot_q[0];
	assign report.slot_two   = rpt_slot_q[1];
	assign report.slot_three = rpt_slot_q[2];
	assign report.slot_four  = rpt_slot_q[3];
	assign report.slot_five  = rpt_slot_q[4];
	assign report.slot_six   = rpt_slot_q[5];
	assign report.indicator  = rpt_ind_q;

endmodule

### src/pad_to_keyboard_report_top.sv
// ----------------------------------------------------------------------------
// pad_to_keyboard_report_top
// Turns polls of two game pad button words into a six-key keyboard report.
// ----------------------------------------------------------------------------
// Use:
//   poll   (sink)  : one beat per poll, pad_one_buttons and pad_two_buttons.
//   report (source): one beat per poll, six keycode slots and the indicator,
//                    taken after all changes of that poll are applied.
// Each poll passes through the queue, the back end walk over 16 button
//   positions times two pads at one slot lookup per cycle, and the output
//   register. The back end fetches a poll from the queue, walks it and loads
//   the output register before it takes the next poll.
// The front end keeps accepting polls while the two-entry queue has room, so
// polls can arrive while the back end is still walking an earlier one.
// Reset clears the previous button words and all slots, sets the indicator
// high and drops any pending report.
// When the receiver stalls, the report beat holds in the output register; the
// back end waits with the next finished report, and the front end stops
// taking polls once the queue is full.
// ----------------------------------------------------------------------------
module pad_to_keyboard_report_top import p2k_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	p2k_poll_if.sink      poll,
	p2k_report_if.source  report
);

	p2k_qstat_t qstat;
	logic       push;
	logic       pop;
	p2k_work_t  push_data;
	p2k_work_t  pop_data;

	p2k_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	p2k_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	p2k_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.report   (report)
	);

endmodule

### src/p2k_checker.sv
// ----------------------------------------------------------------------------
// p2k_checker
// Port-level checks of the pad to keyboard report block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pad_to_keyboard_report_top_macros.svh"

module p2k_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       report_valid,
	input logic       report_ready,
	input logic [7:0] slot_one,
	input logic [7:0] slot_two,
	input logic [7:0] slot_three,
	input logic [7:0] slot_four,
	input logic [7:0] slot_five,
	input logic [7:0] slot_six,
	input logic       indicator
);

	logic all_empty;

	assign all_empty = (slot_one == 8'd0) && (slot_two == 8'd0) && (slot_three == 8'd0)
		&& (slot_four == 8'd0) && (slot_five == 8'd0) && (slot_six == 8'd0);

	// A stalled report beat stays up
	`P2K_ASSERT_NEXT(a_rpt_hold, clk, arst_n, report_valid && !report_ready, report_valid, "report beat dropped while stalled")

	// No report beat right out of reset
	`P2K_ASSERT_ALWAYS(a_rst_quiet, clk, $rose(arst_n), !report_valid, "report beat present at reset release")

	// Empty slots mean the last accepted change was a release, or none came since reset
	`P2K_ASSERT_NOW(a_empty_ind, clk, arst_n, report_valid && all_empty, indicator, "indicator low with all slots empty")

	// A stalled indicator level holds, and so does slot one
	`P2K_ASSERT_NEXT(a_rpt_stable, clk, arst_n, report_valid && !report_ready, $stable(indicator) && $stable(slot_one), "report payload changed while stalled")

endmodule

bind pad_to_keyboard_report_top p2k_checker u_p2k_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.report_valid (report.valid),
	.report_ready (report.ready),
	.slot_one     (report.slot_one),
	.slot_two     (report.slot_two),
	.slot_three   (report.slot_three),
	.slot_four    (report.slot_four),
	.slot_five    (report.slot_five),
	.slot_six     (report.slot_six),
	.indicator    (report.indicator)
);
